/* hw/rtl/quad_cell_normal_stream_assert.svh */
// Assertion macros for the checker file of quad_cell_normal_stream.
// No dependencies; include by bare file name.
`ifndef QUAD_CELL_NORMAL_STREAM_ASSERT_SVH
`define QUAD_CELL_NORMAL_STREAM_ASSERT_SVH

// Concurrent assertion, disabled while reset is high.
`define QCN_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked across reset.
`define QCN_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/qcn_pkg.sv */
// Package for quad_cell_normal_stream: sizes, register indexes and payload types.
// No dependencies.
package qcn_pkg;

   localparam int MAX_ROW_LENGTH = 1024;
   localparam int COORD_WIDTH    = 24;

   localparam int COL_W      = $clog2(MAX_ROW_LENGTH);
   localparam int LEN_W      = $clog2(MAX_ROW_LENGTH + 1);
   localparam int ROW_W      = 16;
   localparam int NORMAL_W   = 52;
   localparam int DIFF_W     = COORD_WIDTH + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int EXT_W      = (SUM_W > NORMAL_W) ? SUM_W : NORMAL_W;
   localparam int VTX_W      = 3 * COORD_WIDTH;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = (LEN_W > ROW_W) ? LEN_W : ROW_W;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_LENGTH = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT  = CSR_IDX_W'(1);

   localparam logic [LEN_W-1:0] ROW_LENGTH_RESET = LEN_W'(MAX_ROW_LENGTH);
   localparam logic [ROW_W-1:0] ROW_COUNT_RESET  = ROW_W'(2);

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] vertex_x;
      logic signed [COORD_WIDTH-1:0] vertex_y;
      logic signed [COORD_WIDTH-1:0] vertex_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [NORMAL_W-1:0] normal_x;
      logic signed [NORMAL_W-1:0] normal_y;
      logic signed [NORMAL_W-1:0] normal_z;
      logic [COL_W-1:0]           cell_column;
      logic [ROW_W-1:0]           cell_row;
      logic                       last_cell;
   } rsp_payload_type;

   typedef struct packed {
      logic [COL_W-1:0] cell_column;
      logic [ROW_W-1:0] cell_row;
      logic             last_cell;
   } qcn_meta_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] x;
      logic signed [DIFF_W-1:0] y;
      logic signed [DIFF_W-1:0] z;
   } qcn_diff_type;

endpackage

/* hw/rtl/quad_cell_normal_stream.sv */
// quad_cell_normal_stream: one vertex per cycle while rsp_ready lets the pipeline
// move, one RAM read and one write per cycle on the line store. A cell passes s1, then
// qcn_cross a, b and o; stalls on rsp_ready back up through this four-entry pipeline.
// Synchronous active-high reset clears counters, corner vertices and valid bits and
// loads row_length 1024, row_count 2; the line store is not cleared and needs no pass.
// Depends on qcn_pkg, qcn_ram, qcn_cross.
module quad_cell_normal_stream import qcn_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [LEN_W-1:0] row_length_ff;
   logic [ROW_W-1:0] row_count_ff;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic             s1_valid_ff;
   logic             s1_produce_ff;
   req_payload_type  s1_cur_ff;
   qcn_meta_type     s1_meta_ff, s1_meta_in;
   req_payload_type  left_ff;
   req_payload_type  upper_left_ff;

   logic [LEN_W-1:0] len_eff;
   logic [ROW_W-1:0] cnt_eff;
   logic             col_end;
   logic             row_end;
   logic             req_xfer;
   logic             s1_adv;
   logic             cross_ready;
   logic [VTX_W-1:0] ram_rd_data;
   req_payload_type  up_vtx;
   qcn_diff_type     ac;
   qcn_diff_type     bd;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= ROW_LENGTH_RESET;
         row_count_ff  <= ROW_COUNT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROW_LENGTH: row_length_ff <= csr_wdata[LEN_W-1:0];
            CSR_ROW_COUNT:  row_count_ff  <= csr_wdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      priority if (row_length_ff < LEN_W'(2)) begin
         len_eff = LEN_W'(2);
      end else if (row_length_ff > LEN_W'(MAX_ROW_LENGTH)) begin
         len_eff = LEN_W'(MAX_ROW_LENGTH);
      end else begin
         len_eff = row_length_ff;
      end
   end

   assign cnt_eff = (row_count_ff < ROW_W'(2)) ? ROW_W'(2) : row_count_ff;
   assign col_end = LEN_W'(col_ff) >= (len_eff - LEN_W'(1));
   assign row_end = row_ff >= (cnt_eff - ROW_W'(1));

   assign col_in = col_end ? '0 : col_ff + COL_W'(1);
   assign row_in = !col_end ? row_ff : (row_end ? '0 : row_ff + ROW_W'(1));

   assign s1_meta_in.cell_column = col_ff - COL_W'(1);
   assign s1_meta_in.cell_row    = row_ff - ROW_W'(1);
   assign s1_meta_in.last_cell   = col_end && row_end;

   assign s1_adv    = s1_valid_ff && (!s1_produce_ff || cross_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_xfer  = req_valid && req_ready;

   // line store: previous row, read and written at the current column
   qcn_ram #(
      .WIDTH (VTX_W),
      .DEPTH (MAX_ROW_LENGTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (req_xfer),
      .wr_addr (col_ff),
      .wr_data (req_data),
      .rd_en   (req_xfer),
      .rd_addr (col_ff),
      .rd_data (ram_rd_data)
   );

   assign up_vtx = req_payload_type'(ram_rd_data);

   // AC = C - A, BD = D - B
   assign ac.x = DIFF_W'(s1_cur_ff.vertex_x) - DIFF_W'(upper_left_ff.vertex_x);
   assign ac.y = DIFF_W'(s1_cur_ff.vertex_y) - DIFF_W'(upper_left_ff.vertex_y);
   assign ac.z = DIFF_W'(s1_cur_ff.vertex_z) - DIFF_W'(upper_left_ff.vertex_z);
   assign bd.x = DIFF_W'(left_ff.vertex_x) - DIFF_W'(up_vtx.vertex_x);
   assign bd.y = DIFF_W'(left_ff.vertex_y) - DIFF_W'(up_vtx.vertex_y);
   assign bd.z = DIFF_W'(left_ff.vertex_z) - DIFF_W'(up_vtx.vertex_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         left_ff       <= '0;
         upper_left_ff <= '0;
      end else begin
         if (req_xfer) begin
            col_ff      <= col_in;
            row_ff      <= row_in;
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            left_ff       <= s1_cur_ff;
            upper_left_ff <= up_vtx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_cur_ff     <= req_data;
         s1_meta_ff    <= s1_meta_in;
         s1_produce_ff <= (col_ff != '0) && (row_ff != '0);
      end
   end

   qcn_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff && s1_produce_ff),
      .in_ready  (cross_ready),
      .in_ac     (ac),
      .in_bd     (bd),
      .in_meta   (s1_meta_ff),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

/* hw/rtl/qcn_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module qcn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read and write of the same entry return the old data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/qcn_cross.sv */
// Cross product pipeline of quad_cell_normal_stream: difference registers,
// products, halved differences into the output register. Depends on qcn_pkg.
module qcn_cross import qcn_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  qcn_diff_type    in_ac,
   input  qcn_diff_type    in_bd,
   input  qcn_meta_type    in_meta,
   output logic            out_valid,
   input  logic            out_ready,
   output rsp_payload_type out_data
);

   function automatic logic signed [NORMAL_W-1:0] half_diff(
      input logic signed [PROD_W-1:0] p,
      input logic signed [PROD_W-1:0] q
   );
      logic signed [SUM_W-1:0] s;
      logic signed [EXT_W-1:0] e;
      s = SUM_W'(p) - SUM_W'(q);
      e = EXT_W'(s >>> 1);
      return e[NORMAL_W-1:0];
   endfunction

   logic                     a_valid_ff;
   qcn_diff_type             a_ac_ff;
   qcn_diff_type             a_bd_ff;
   qcn_meta_type             a_meta_ff;

   logic                     b_valid_ff;
   logic signed [PROD_W-1:0] b_yz_ff, b_zy_ff, b_zx_ff, b_xz_ff, b_xy_ff, b_yx_ff;
   logic signed [PROD_W-1:0] b_yz_in, b_zy_in, b_zx_in, b_xz_in, b_xy_in, b_yx_in;
   qcn_meta_type             b_meta_ff;

   logic                     o_valid_ff;
   rsp_payload_type          o_data_ff;
   rsp_payload_type          o_data_in;

   logic                     load_o;
   logic                     load_b;
   logic                     load_a;

   assign load_o   = !o_valid_ff || out_ready;
   assign load_b   = !b_valid_ff || load_o;
   assign load_a   = !a_valid_ff || load_b;
   assign in_ready = load_a;

   assign b_yz_in = $signed(a_ac_ff.y) * $signed(a_bd_ff.z);
   assign b_zy_in = $signed(a_ac_ff.z) * $signed(a_bd_ff.y);
   assign b_zx_in = $signed(a_ac_ff.z) * $signed(a_bd_ff.x);
   assign b_xz_in = $signed(a_ac_ff.x) * $signed(a_bd_ff.z);
   assign b_xy_in = $signed(a_ac_ff.x) * $signed(a_bd_ff.y);
   assign b_yx_in = $signed(a_ac_ff.y) * $signed(a_bd_ff.x);

   always_comb begin
      o_data_in.normal_x    = half_diff(b_yz_ff, b_zy_ff);
      o_data_in.normal_y    = half_diff(b_zx_ff, b_xz_ff);
      o_data_in.normal_z    = half_diff(b_xy_ff, b_yx_ff);
      o_data_in.cell_column = b_meta_ff.cell_column;
      o_data_in.cell_row    = b_meta_ff.cell_row;
      o_data_in.last_cell   = b_meta_ff.last_cell;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (load_a) begin
            a_valid_ff <= in_valid;
         end
         if (load_b) begin
            b_valid_ff <= a_valid_ff;
         end
         if (load_o) begin
            o_valid_ff <= b_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_a) begin
         a_ac_ff   <= in_ac;
         a_bd_ff   <= in_bd;
         a_meta_ff <= in_meta;
      end
      if (load_b) begin
         b_yz_ff   <= b_yz_in;
         b_zy_ff   <= b_zy_in;
         b_zx_ff   <= b_zx_in;
         b_xz_ff   <= b_xz_in;
         b_xy_ff   <= b_xy_in;
         b_yx_ff   <= b_yx_in;
         b_meta_ff <= a_meta_ff;
      end
      if (load_o) begin
         o_data_ff <= o_data_in;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_data  = o_data_ff;

endmodule

/* hw/rtl/qcn_checker.sv */
// Port-level checker for quad_cell_normal_stream, bound to the top level.
// Depends on qcn_pkg and quad_cell_normal_stream_assert.svh.
`include "quad_cell_normal_stream_assert.svh"

module qcn_checker import qcn_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   // a stalled result transfer holds
   `QCN_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)), "rsp changed while stalled")

   // a free output register never blocks the input
   `QCN_ASSERT(a_ready_when_free, clock, reset, (!rsp_valid || rsp_ready) |-> req_ready, "req_ready low with output free")

   // reset empties the pipeline
   `QCN_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "rsp_valid after reset")

   // after reset the input side is open again
   `QCN_ASSERT_ALWAYS(a_reset_ready, clock, reset |=> req_ready, "req_ready low after reset")

endmodule

bind quad_cell_normal_stream qcn_checker u_qcn_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* sim/testbench.sv */
`timescale 1ns / 100ps
// Testbench for quad_cell_normal_stream: streams vertex meshes of changing size, predicts
// each cell's surface vector in a scoreboard class and checks every result transfer.
// Depends on qcn_pkg and the quad_cell_normal_stream RTL.
module testbench;
   import qcn_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = CSR_IDX_W'(3);
   localparam int COORD_MAX       = (1 << (COORD_WIDTH - 1)) - 1;
   localparam int COORD_MIN       = -(1 << (COORD_WIDTH - 1));
   localparam int RANDOM_VERTICES = 680;
   localparam int SETTLE_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int REPORT_LIMIT    = 10;

   typedef enum int {PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FREE} pace_kind;

   class cell_normal_checker;
      rsp_payload_type due_cells[$];
      req_payload_type line_store[MAX_ROW_LENGTH];
      req_payload_type left_vtx;
      req_payload_type upper_left_vtx;
      int unsigned     column;
      int unsigned     row;
      int unsigned     row_length;
      int unsigned     row_count;
      int              mismatches;

      function new();
         left_vtx       = '0;
         upper_left_vtx = '0;
         column         = 0;
         row            = 0;
         row_length     = ROW_LENGTH_RESET;
         row_count      = ROW_COUNT_RESET;
         mismatches     = 0;
         foreach (line_store[k]) line_store[k] = '0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_ROW_LENGTH: row_length = value[LEN_W-1:0];
            CSR_ROW_COUNT:  row_count  = value[ROW_W-1:0];
            default: ;
         endcase
      endfunction

      function longint coord(logic [COORD_WIDTH-1:0] v);
         return longint'($signed(v));
      endfunction

      // cell (i-1,j-1) is (AC x BD) / 2, halved by arithmetic shift
      function void take_vertex(req_payload_type cur);
         int unsigned     len, cnt;
         bit              col_end, row_end;
         req_payload_type up;
         longint          acx, acy, acz, bdx, bdy, bdz, half_x, half_y, half_z;
         rsp_payload_type due;
         len = (row_length < 2) ? 2 :
               (row_length > MAX_ROW_LENGTH) ? MAX_ROW_LENGTH : row_length;
         cnt = (row_count < 2) ? 2 : row_count;
         up = line_store[column];
         col_end = (column >= len - 1);
         row_end = (row >= cnt - 1);
         if (column >= 1 && row >= 1) begin
            acx = coord(cur.vertex_x) - coord(upper_left_vtx.vertex_x);
            acy = coord(cur.vertex_y) - coord(upper_left_vtx.vertex_y);
            acz = coord(cur.vertex_z) - coord(upper_left_vtx.vertex_z);
            bdx = coord(left_vtx.vertex_x) - coord(up.vertex_x);
            bdy = coord(left_vtx.vertex_y) - coord(up.vertex_y);
            bdz = coord(left_vtx.vertex_z) - coord(up.vertex_z);
            half_x = (acy * bdz - acz * bdy) >>> 1;
            half_y = (acz * bdx - acx * bdz) >>> 1;
            half_z = (acx * bdy - acy * bdx) >>> 1;
            due.normal_x    = half_x[NORMAL_W-1:0];
            due.normal_y    = half_y[NORMAL_W-1:0];
            due.normal_z    = half_z[NORMAL_W-1:0];
            due.cell_column = COL_W'(column - 1);
            due.cell_row    = ROW_W'(row - 1);
            due.last_cell   = col_end && row_end;
            due_cells.push_back(due);
         end
         line_store[column] = cur;
         upper_left_vtx = up;
         left_vtx = cur;
         if (col_end) begin
            column = 0;
            row = row_end ? 0 : row + 1;
         end else begin
            column++;
         end
      endfunction

      function void report(string text);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) $display("MISMATCH %s", text);
      endfunction

      function void compare(string field, logic [NORMAL_W-1:0] want_v,
                            logic [NORMAL_W-1:0] got_v, rsp_payload_type want);
         if (got_v !== want_v)
            report($sformatf("cell (%0d,%0d) %s: expected %0h, got %0h",
                             want.cell_column, want.cell_row, field, want_v, got_v));
      endfunction

      function void check_cell(rsp_payload_type got);
         rsp_payload_type want;
         if (due_cells.size() == 0) begin
            report($sformatf("cell (%0d,%0d) arrived with none expected",
                             got.cell_column, got.cell_row));
            return;
         end
         want = due_cells.pop_front();
         compare("normal_x", want.normal_x, got.normal_x, want);
         compare("normal_y", want.normal_y, got.normal_y, want);
         compare("normal_z", want.normal_z, got.normal_z, want);
         compare("cell_column", want.cell_column, got.cell_column, want);
         compare("cell_row", want.cell_row, got.cell_row, want);
         compare("last_cell", want.last_cell, got.last_cell, want);
      endfunction
   endclass

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_payload_type       req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_ROW_LENGTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int quiet_cycles  = 0;
   cell_normal_checker cells;

   quad_cell_normal_stream DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) cells.take_vertex(req_data);
         if (rsp_valid && rsp_ready) cells.check_cell(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("** quad_cell_normal_stream: FAILED **");
      $finish;
   end

   task automatic set_pace(pace_kind mode);
      case (mode)
         PACE_SLOW_SINK: begin
            send_idle_pct = 16;
            recv_idle_pct = 55;
         end
         PACE_SLOW_SOURCE: begin
            send_idle_pct = 55;
            recv_idle_pct = 16;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
   endtask

   function automatic req_payload_type mk_vertex(int x, int y, int z);
      req_payload_type v;
      v.vertex_x = COORD_WIDTH'(x);
      v.vertex_y = COORD_WIDTH'(y);
      v.vertex_z = COORD_WIDTH'(z);
      return v;
   endfunction

   function automatic logic [COORD_WIDTH-1:0] rand_coord();
      case ($urandom_range(0, 9))
         0: return COORD_WIDTH'(COORD_MAX);
         1: return COORD_WIDTH'(COORD_MIN);
         2, 3, 4: return COORD_WIDTH'(int'($urandom_range(0, 200)) - 100);
         default: return COORD_WIDTH'($urandom());
      endcase
   endfunction

   function automatic req_payload_type rand_vertex();
      req_payload_type v;
      v.vertex_x = rand_coord();
      v.vertex_y = rand_coord();
      v.vertex_z = rand_coord();
      return v;
   endfunction

   // called at a rising edge; returns at the edge of the transfer
   task automatic push_vertex(input req_payload_type v);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= v;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (cells.due_cells.size() != 0);
   endtask

   // cells without a result may still be in flight after the last result
   task automatic settle();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_regs(int unsigned len, int unsigned cnt, bit spare);
      logic [CSR_DATA_W-1:0] len_word;
      len_word = CSR_DATA_W'($urandom());
      len_word[LEN_W-1:0] = LEN_W'(len);
      csr_we    <= 1'b1;
      csr_index <= CSR_ROW_LENGTH;
      csr_wdata <= len_word;
      cells.write_reg(CSR_ROW_LENGTH, len_word);
      @(posedge clock);
      csr_index <= CSR_ROW_COUNT;
      csr_wdata <= CSR_DATA_W'(cnt);
      cells.write_reg(CSR_ROW_COUNT, CSR_DATA_W'(cnt));
      @(posedge clock);
      if (spare) begin
         csr_index <= CSR_SPARE_LO;
         csr_wdata <= CSR_DATA_W'($urandom());
         @(posedge clock);
         csr_index <= CSR_SPARE_HI;
         csr_wdata <= CSR_DATA_W'($urandom());
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   initial begin
      int unsigned sent, burst, len, cnt;
      cells = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      set_pace(PACE_SLOW_SINK);

      // 3x2 mesh of extreme corners, writes to unused indexes are ignored
      set_regs(3, 2, 1'b1);
      push_vertex(mk_vertex(COORD_MIN, COORD_MIN, COORD_MIN));
      push_vertex(mk_vertex(COORD_MAX, COORD_MIN, COORD_MAX));
      push_vertex(mk_vertex(0, 0, 0));
      push_vertex(mk_vertex(COORD_MIN, COORD_MAX, COORD_MAX));
      push_vertex(mk_vertex(COORD_MAX, COORD_MAX, COORD_MIN));
      push_vertex(mk_vertex(-1, -1, -1));
      settle();

      // sizes below range act as 2x2
      set_regs(1, 0, 1'b0);
      push_vertex(mk_vertex(COORD_MAX, 0, COORD_MIN));
      push_vertex(mk_vertex(COORD_MIN, COORD_MAX, 0));
      push_vertex(mk_vertex(0, COORD_MIN, COORD_MAX));
      push_vertex(mk_vertex(COORD_MAX, COORD_MAX, COORD_MAX));
      settle();

      // narrow mesh, small values with odd sums
      set_regs(2, 3, 1'b0);
      push_vertex(mk_vertex(0, 0, 0));
      push_vertex(mk_vertex(1, 0, 0));
      push_vertex(mk_vertex(0, 1, 0));
      push_vertex(mk_vertex(1, 1, 1));
      push_vertex(mk_vertex(0, 2, -1));
      push_vertex(mk_vertex(1, 2, 3));
      settle();

      // full-width row fills the whole line store, later sizes may change mid-mesh
      set_regs(MAX_ROW_LENGTH, 16'hFFFF, 1'b0);
      repeat (MAX_ROW_LENGTH + 24) push_vertex(rand_vertex());

      sent = 0;
      while (sent < RANDOM_VERTICES) begin
         settle();
         case ($urandom_range(0, 15))
            0: len = 0;
            1: len = 1;
            2: len = MAX_ROW_LENGTH;
            3: len = (1 << LEN_W) - 1;
            4: len = $urandom_range(13, (1 << LEN_W) - 1);
            default: len = $urandom_range(2, 12);
         endcase
         case ($urandom_range(0, 11))
            0: cnt = 0;
            1: cnt = 1;
            2: cnt = 16'hFFFF;
            3: cnt = $urandom_range(7, 16'hFFFF);
            default: cnt = $urandom_range(2, 6);
         endcase
         set_regs(len, cnt, $urandom_range(0, 7) == 0);
         burst = $urandom_range(8, 100);
         repeat (burst) begin
            if (sent < RANDOM_VERTICES / 3) set_pace(PACE_SLOW_SINK);
            else if (sent < 2 * RANDOM_VERTICES / 3) set_pace(PACE_SLOW_SOURCE);
            else set_pace(PACE_FREE);
            if ($urandom_range(0, 59) == 0) drain();
            push_vertex(rand_vertex());
            sent++;
         end
      end

      settle();
      if (cells.due_cells.size() != 0)
         $display("%0d expected cells never arrived", cells.due_cells.size());
      if (cells.mismatches == 0 && cells.due_cells.size() == 0)
         $display("** quad_cell_normal_stream: PASSED **");
      else
         $display("** quad_cell_normal_stream: FAILED **");
      $finish;
   end

endmodule
